/* rtl/core/vector3_normalize_assert.svh */
// assertion macros for the vector normaliser checker
// needs a clk and arst_n in the scope where a macro is used
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// condition holds in the same cycle
`define VN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vector3_normalize check failed");

// condition holds in the following cycle
`define VN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vector3_normalize check failed");

`endif

/* rtl/core/vn_pkg.sv */
// shared constants for the vector normaliser
// no dependencies
package vn_pkg;
	localparam int COMP_PORT_W = 32;
	localparam int LENGTH_W = 32;
endpackage

/* rtl/core/vector3_normalize.sv */
// vector3_normalize: top level of the 3d vector normaliser
// uses vn_pkg, vn_sqrt and three vn_div_lane instances
//
// input channel: comp_x/comp_y/comp_z, signed q16.16, a transaction is taken
// when in_valid is high and in_stall is low. only the low COMPONENT_BITS
// bits of each component count, sign-extended.
// output channel: unit_x/unit_y/unit_z (signed, UNIT_FRAC_BITS fraction bits,
// truncated toward zero), vec_length (floor of the euclidean length, q16.16)
// and zero_length; a transaction completes when out_valid is high and
// out_stall is low. a zero vector gives all zeros with zero_length set.
// the pipeline stages are magnitude, square, sum, one square-root stage per
// length bit, one divider stage per quotient bit in each of three parallel
// lanes, and the output register. throughput is one vector per cycle; the
// pipeline holds as a whole only while a finished result sits in the output
// register and out_stall is high. reset empties the pipeline; there is no
// other state.
module vector3_normalize #(
	parameter int COMPONENT_BITS = 32,
	parameter int UNIT_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [vn_pkg::COMP_PORT_W-1:0] comp_x,
	input  logic signed [vn_pkg::COMP_PORT_W-1:0] comp_y,
	input  logic signed [vn_pkg::COMP_PORT_W-1:0] comp_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [UNIT_FRAC_BITS+1:0]    unit_x,
	output logic signed [UNIT_FRAC_BITS+1:0]    unit_y,
	output logic signed [UNIT_FRAC_BITS+1:0]    unit_z,
	output logic [vn_pkg::LENGTH_W-1:0]         vec_length,
	output logic                                zero_length
);
	import vn_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int F = UNIT_FRAC_BITS;
	localparam int SIDE_W = 3 * (CB + 1);

	logic en;
	logic [CB-1:0] comp_v [0:2];
	logic [CB-1:0] mag_s1 [0:2];
	logic          neg_s1 [0:2];
	logic          v_s1;
	logic [2*CB-1:0] sq_s2 [0:2];
	logic [CB-1:0]   mag_s2 [0:2];
	logic            neg_s2 [0:2];
	logic            v_s2;
	logic [2*CB-1:0] sum_s3;
	logic [SIDE_W-1:0] side_s3;
	logic            v_s3;
	logic            sq_valid;
	logic [CB-1:0]   sq_root;
	logic [SIDE_W-1:0] sq_side;
	logic [CB-1:0]   len_q [0:F+1];
	logic            lv_q  [0:F+1];
	logic signed [F+1:0] lane_unit [0:2];
	logic            out_valid_q;
	logic signed [F+1:0] unit_x_q, unit_y_q, unit_z_q;
	logic [LENGTH_W-1:0] len_out_q;
	logic            zero_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	assign comp_v[0] = comp_x[CB-1:0];
	assign comp_v[1] = comp_y[CB-1:0];
	assign comp_v[2] = comp_z[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_comp
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[c] <= comp_v[c][CB-1];
				mag_s1[c] <= comp_v[c][CB-1] ? (~comp_v[c] + CB'(1)) : comp_v[c];
				sq_s2[c]  <= (2*CB)'(mag_s1[c]) * (2*CB)'(mag_s1[c]);
				mag_s2[c] <= mag_s1[c];
				neg_s2[c] <= neg_s1[c];
			end
		end

		vn_div_lane #(.CB(CB), .F(F)) u_lane (
			.clk  (clk),
			.en   (en),
			.mag  (sq_side[c*(CB+1) +: CB]),
			.neg  (sq_side[c*(CB+1) + CB]),
			.den  (sq_root),
			.unit (lane_unit[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3 <= {neg_s2[2], mag_s2[2], neg_s2[1], mag_s2[1], neg_s2[0], mag_s2[0]};
		end
	end

	vn_sqrt #(.CB(CB), .SIDE_W(SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// length and valid travel beside the divider lanes
	assign len_q[0] = sq_root;
	assign lv_q[0]  = sq_valid;

	for (genvar i = 0; i <= F; i++) begin : g_delay
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lv_q[i+1] <= 1'b0;
			end else if (en) begin
				lv_q[i+1] <= lv_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_q[i+1] <= len_q[i];
			end
		end
	end

	// merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= lv_q[F+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q    <= len_q[F+1] == '0;
			len_out_q <= LENGTH_W'(len_q[F+1]);
			unit_x_q  <= (len_q[F+1] == '0) ? '0 : lane_unit[0];
			unit_y_q  <= (len_q[F+1] == '0) ? '0 : lane_unit[1];
			unit_z_q  <= (len_q[F+1] == '0) ? '0 : lane_unit[2];
		end
	end

	assign out_valid   = out_valid_q;
	assign unit_x      = unit_x_q;
	assign unit_y      = unit_y_q;
	assign unit_z      = unit_z_q;
	assign vec_length  = len_out_q;
	assign zero_length = zero_q;
endmodule

/* rtl/core/vn_sqrt.sv */
// pipelined floor square root, one root bit per stage
// carries a sideband word alongside; no package dependencies
module vn_sqrt #(
	parameter int CB = 32,
	parameter int SIDE_W = 99
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*CB-1:0]   radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [CB-1:0]     root,
	output logic [SIDE_W-1:0] out_side
);
	localparam int SW = 2 * CB;

	logic [SW-1:0]     rem_q  [0:CB-1];
	logic [CB-1:0]     root_q [0:CB];
	logic [SIDE_W-1:0] side_q [0:CB];
	logic              v_q    [0:CB];

	assign rem_q[0]  = radicand;
	assign root_q[0] = '0;
	assign side_q[0] = in_side;
	assign v_q[0]    = in_valid;

	for (genvar i = 0; i < CB; i++) begin : g_stage
		localparam int K = CB - 1 - i;
		logic [SW:0] trial;
		logic        take;

		assign trial = ((SW+1)'(root_q[i]) << (K + 1)) | ((SW+1)'(1) << (2 * K));
		assign take  = {1'b0, rem_q[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[i+1] <= take ? (root_q[i] | (CB'(1) << K)) : root_q[i];
				side_q[i+1] <= side_q[i];
			end
		end

		if (i < CB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i+1] <= take ? SW'({1'b0, rem_q[i]} - trial) : rem_q[i];
				end
			end
		end
	end

	assign out_valid = v_q[CB];
	assign root      = root_q[CB];
	assign out_side  = side_q[CB];
endmodule

/* rtl/core/vn_div_lane.sv */
// one divider lane: magnitude scaled by 2^F over the length, one quotient bit per stage
// result is signed with F+2 bits; no package dependencies
module vn_div_lane #(
	parameter int CB = 32,
	parameter int F = 14
) (
	input  logic                clk,
	input  logic                en,
	input  logic [CB-1:0]       mag,
	input  logic                neg,
	input  logic [CB-1:0]       den,
	output logic signed [F+1:0] unit
);
	localparam int NW = CB + F;

	logic [NW-1:0] rem_q [0:F];
	logic [CB-1:0] den_q [0:F];
	logic [F:0]    q_q   [0:F+1];
	logic          neg_q [0:F+1];

	assign rem_q[0] = {mag, {F{1'b0}}};
	assign den_q[0] = den;
	assign q_q[0]   = '0;
	assign neg_q[0] = neg;

	for (genvar i = 0; i <= F; i++) begin : g_stage
		localparam int J = F - i;
		logic [NW:0] sub;
		logic        take;

		assign sub  = (NW+1)'(den_q[i]) << J;
		assign take = {1'b0, rem_q[i]} >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				q_q[i+1]   <= take ? (q_q[i] | ((F+1)'(1) << J)) : q_q[i];
				neg_q[i+1] <= neg_q[i];
			end
		end

		if (i < F) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i+1] <= take ? NW'({1'b0, rem_q[i]} - sub) : rem_q[i];
					den_q[i+1] <= den_q[i];
				end
			end
		end
	end

	assign unit = neg_q[F+1] ? -$signed({1'b0, q_q[F+1]}) : $signed({1'b0, q_q[F+1]});
endmodule

/* rtl/core/vn_checker.sv */
// port-level checks for vector3_normalize, bound to the top level
// uses vn_pkg and the macros in vector3_normalize_assert.svh
`include "vector3_normalize_assert.svh"

module vn_checker #(
	parameter int UNIT_FRAC_BITS = 14
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [UNIT_FRAC_BITS+1:0] unit_x,
	input logic signed [UNIT_FRAC_BITS+1:0] unit_y,
	input logic signed [UNIT_FRAC_BITS+1:0] unit_z,
	input logic [vn_pkg::LENGTH_W-1:0]      vec_length,
	input logic                             zero_length
);
	import vn_pkg::*;

	// a held result keeps its length, x component and zero flag
	`VN_ASSERT_NEXT(a_hold, out_valid && out_stall, $stable(vec_length) && $stable(unit_x) && $stable(zero_length))
	// input is only held back by a stalled result
	`VN_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
	// zero flag matches the length
	`VN_ASSERT_NOW(a_zero_len, out_valid, zero_length == (vec_length == '0))
	// zero vector gives zero unit components
	`VN_ASSERT_NOW(a_zero_unit, out_valid && zero_length, unit_x == '0 && unit_y == '0 && unit_z == '0)
endmodule

bind vector3_normalize vn_checker #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_vn_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for vector3_normalize: queued vectors are driven in,
// results are checked against an in-bench normaliser; depends on vn_pkg and the rtl
module tb_top;
	localparam int COMPONENT_BITS = 32;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int LATENCY = COMPONENT_BITS + UNIT_FRAC_BITS + 5;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [UNIT_FRAC_BITS+1:0] ux;
		logic signed [UNIT_FRAC_BITS+1:0] uy;
		logic signed [UNIT_FRAC_BITS+1:0] uz;
		logic [31:0] len;
		logic zero;
	} unit_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [vn_pkg::COMP_PORT_W-1:0] comp_x, comp_y, comp_z;
	logic signed [UNIT_FRAC_BITS+1:0] unit_x, unit_y, unit_z;
	logic [vn_pkg::LENGTH_W-1:0] vec_length;
	logic zero_length;

	vec_t pending_vecs[$];
	unit_t expected_units[$];
	int send_idle_pct, recv_idle_pct;
	bit hold_off;
	int mismatches, checked, zero_seen;

	vector3_normalize #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.UNIT_FRAC_BITS(UNIT_FRAC_BITS)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.vec_length(vec_length), .zero_length(zero_length)
	);

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem, root, b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem && b != 0)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic unit_t normalise(input vec_t v);
		logic [63:0] mag[3];
		logic neg[3];
		logic [63:0] sum, len, q;
		logic [31:0] c[3];
		unit_t r;
		c[0] = v.x;
		c[1] = v.y;
		c[2] = v.z;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i][31];
			mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, c[i]} : {32'd0, c[i]};
			sum = sum + mag[i] * mag[i];
		end
		len = isqrt64(sum);
		r = '0;
		if (len == 0) begin
			r.zero = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] << UNIT_FRAC_BITS) / len;
			if (neg[i])
				q = ~q + 1;
			if (i == 0) r.ux = q[UNIT_FRAC_BITS+1:0];
			else if (i == 1) r.uy = q[UNIT_FRAC_BITS+1:0];
			else r.uz = q[UNIT_FRAC_BITS+1:0];
		end
		r.len = len[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 255) - 128;
			2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			4: return 32'd0;
			default: return 32'($signed(32'($urandom)) >>> $urandom_range(0, 31));
		endcase
	endfunction

	task automatic push_vec(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		vec_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		pending_vecs.push_back(v);
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			comp_x <= 0;
			comp_y <= 0;
			comp_z <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				expected_units.push_back(normalise({comp_x, comp_y, comp_z}));
			if (pending_vecs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				vec_t v;
				v = pending_vecs.pop_front();
				in_valid <= 1;
				comp_x <= v.x;
				comp_y <= v.y;
				comp_z <= v.z;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				unit_t got, want;
				got = '{unit_x, unit_y, unit_z, vec_length, zero_length};
				checked++;
				if (zero_length) zero_seen++;
				if (expected_units.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: %p", got);
				end else begin
					want = expected_units.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic wait_drained();
		while (pending_vecs.size() > 0 || in_valid || expected_units.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int total;
		arst_n = 0;
		send_idle_pct = 26;
		recv_idle_pct = 51;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		push_vec(0, 0, 0);
		push_vec(32'h8000_0000, 0, 0);
		push_vec(0, 32'h8000_0000, 0);
		push_vec(0, 0, 32'h8000_0000);
		push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		push_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		push_vec(1, 0, 0);
		push_vec(0, 32'hffff_ffff, 0);
		push_vec(0, 0, 1);
		push_vec(1, 1, 1);
		push_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		push_vec(32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
		push_vec(32'h0003_0000, 32'hfffc_0000, 0);
		push_vec(32'hffff_ffff, 0, 32'h7fff_ffff);
		push_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
		push_vec(32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0);
		for (int i = 0; i < 180; i++)
			push_vec(rand_comp(), rand_comp(), rand_comp());
		wait_drained();

		// sender pauses until every result is back, then the other idling mix
		send_idle_pct = 51;
		recv_idle_pct = 26;
		for (int i = 0; i < 180; i++)
			push_vec(rand_comp(), rand_comp(), rand_comp());
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off <= 1;
				repeat (300) @(posedge clk);
				hold_off <= 0;
			end
		join_none
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 190; i++)
			push_vec(rand_comp(), rand_comp(), rand_comp());
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);

		total = checked;
		$display("normalised %0d vectors (%0d zero length) across three idling mixes",
			total, zero_seen);
		$display("including extreme components and a long output hold-off");
		if (mismatches == 0 && expected_units.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/vn_pkg.sv
rtl/core/vn_sqrt.sv
rtl/core/vn_div_lane.sv
rtl/core/vector3_normalize.sv
rtl/core/vn_checker.sv
dv/tb_top.sv
